// File: hw/rtl/ppmf_pkg.sv
// Shared types and constants of the pulse period median filter.
`timescale 1ns / 1ps

package ppmf_pkg;

    localparam int DATA_W           = 32;
    localparam int WINDOW_DEF       = 10;
    localparam logic [DATA_W-1:0] MIN_PERIOD_RESET = 32'd100;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SORT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic phase;
    } t_sort_ctrl;

endpackage

// File: hw/rtl/ppmf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module ppmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 10,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/ppmf_sorter.sv
// Working copy of the ring, sorted by odd-even transposition, with median selection.
`timescale 1ns / 1ps

module ppmf_sorter #(
    parameter int WINDOW = ppmf_pkg::WINDOW_DEF
) (
    input  logic                        i_clk,
    input  ppmf_pkg::t_sort_ctrl        i_ctrl,
    input  logic [ppmf_pkg::DATA_W-1:0] i_load_data,
    output logic [ppmf_pkg::DATA_W-1:0] o_median
);

    logic [ppmf_pkg::DATA_W-1:0] r_buf [WINDOW];
    logic [ppmf_pkg::DATA_W-1:0] n_buf [WINDOW];

    always_comb begin
        n_buf = r_buf;
        if (i_ctrl.load) begin
            for (int i = 0; i < WINDOW - 1; i++) begin
                n_buf[i] = r_buf[i+1];
            end
            n_buf[WINDOW-1] = i_load_data;
        end else if (i_ctrl.step) begin
            for (int i = 0; i < WINDOW - 1; i++) begin
                if ((((i % 2) == 1) == i_ctrl.phase) && (r_buf[i] > r_buf[i+1])) begin
                    n_buf[i]   = r_buf[i+1];
                    n_buf[i+1] = r_buf[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    generate
        if ((WINDOW % 2) == 1) begin : g_odd
            assign o_median = r_buf[WINDOW/2];
        end else begin : g_even
            logic [ppmf_pkg::DATA_W:0] mid_sum;
            assign mid_sum  = {1'b0, r_buf[WINDOW/2-1]} + {1'b0, r_buf[WINDOW/2]};
            assign o_median = mid_sum[ppmf_pkg::DATA_W:1];
        end
    endgenerate

endmodule

// File: hw/rtl/pulse_period_median_filter_top.sv
// Top level of the pulse period median filter.
// Each pulse passes through the transfer, the reading of the ring entries into the sorter,
// the sort passes and the loading of the output register; o_stall holds off a new pulse
// until that load. A new pulse is taken while the previous result still waits in the
// output register.
// Reset is synchronous and active low; it clears the timestamp, the write index and the
// per-entry valid bits, so unwritten ring entries read as zero without a clearing pass.
`timescale 1ns / 1ps

module pulse_period_median_filter_top #(
    parameter int WINDOW = ppmf_pkg::WINDOW_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [ppmf_pkg::DATA_W-1:0] i_cfg_wr_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [ppmf_pkg::DATA_W-1:0] i_pulse_time_us,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ppmf_pkg::DATA_W-1:0] o_period_us,
    output logic                        o_accepted,
    output logic [ppmf_pkg::DATA_W-1:0] o_median_period_us
);

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);

    ppmf_pkg::t_state r_state;
    ppmf_pkg::t_state n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    logic [ppmf_pkg::DATA_W-1:0] r_min;
    logic [ppmf_pkg::DATA_W-1:0] r_last;
    logic [IDX_W-1:0]            r_widx;
    logic [WINDOW-1:0]           r_valid;
    logic [ppmf_pkg::DATA_W-1:0] r_period;
    logic                        r_acc;
    logic                        r_rd_vld;

    logic                        r_out_valid;
    logic [ppmf_pkg::DATA_W-1:0] r_out_period;
    logic                        r_out_acc;
    logic [ppmf_pkg::DATA_W-1:0] r_out_median;

    logic                        in_xfer;
    logic [ppmf_pkg::DATA_W-1:0] in_period;
    logic                        in_ok;
    logic                        ram_wr_en;
    logic                        ram_rd_en;
    logic [ppmf_pkg::DATA_W-1:0] ram_rd_data;
    logic [ppmf_pkg::DATA_W-1:0] load_data;
    logic [ppmf_pkg::DATA_W-1:0] median;
    logic                        out_load;
    ppmf_pkg::t_sort_ctrl        sort_ctrl;

    assign o_stall   = (r_state != ppmf_pkg::ST_IDLE);
    assign in_xfer   = i_valid && !o_stall;
    assign in_period = i_pulse_time_us - r_last;
    assign in_ok     = (in_period >= r_min);
    assign ram_wr_en = in_xfer && in_ok;
    assign load_data = r_rd_vld ? ram_rd_data : '0;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ppmf_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ppmf_pkg::ST_READ;
                    n_cnt   = '0;
                end
            end
            ppmf_pkg::ST_READ: begin
                if (r_cnt == CNT_W'(WINDOW)) begin
                    n_state = ppmf_pkg::ST_SORT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ppmf_pkg::ST_SORT: begin
                if (r_cnt == CNT_W'(WINDOW - 1)) begin
                    n_state = ppmf_pkg::ST_DONE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ppmf_pkg::ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = ppmf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ppmf_pkg::ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_comb begin
        ram_rd_en       = 1'b0;
        out_load        = 1'b0;
        sort_ctrl.load  = 1'b0;
        sort_ctrl.step  = 1'b0;
        sort_ctrl.phase = r_cnt[0];
        case (r_state)
            ppmf_pkg::ST_READ: begin
                ram_rd_en      = (r_cnt != CNT_W'(WINDOW));
                sort_ctrl.load = (r_cnt != '0);
            end
            ppmf_pkg::ST_SORT: begin
                sort_ctrl.step = 1'b1;
            end
            ppmf_pkg::ST_DONE: begin
                out_load = !r_out_valid || !i_stall;
            end
            default: begin
                ram_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ppmf_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_min       <= ppmf_pkg::MIN_PERIOD_RESET;
            r_last      <= '0;
            r_widx      <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_wr_en) begin
                r_min <= i_cfg_wr_data;
            end
            if (in_xfer) begin
                r_last <= i_pulse_time_us;
            end
            if (ram_wr_en) begin
                r_valid[r_widx] <= 1'b1;
                if (r_widx == IDX_W'(WINDOW - 1)) begin
                    r_widx <= '0;
                end else begin
                    r_widx <= r_widx + 1'b1;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_period <= in_period;
            r_acc    <= in_ok;
        end
        if (ram_rd_en) begin
            r_rd_vld <= r_valid[r_cnt[IDX_W-1:0]];
        end
        if (out_load) begin
            r_out_period <= r_period;
            r_out_acc    <= r_acc;
            r_out_median <= median;
        end
    end

    ppmf_ram #(
        .WIDTH (ppmf_pkg::DATA_W),
        .DEPTH (WINDOW),
        .AW    (IDX_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_widx),
        .i_wr_data (in_period),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_cnt[IDX_W-1:0]),
        .o_rd_data (ram_rd_data)
    );

    ppmf_sorter #(
        .WINDOW (WINDOW)
    ) u_sorter (
        .i_clk       (i_clk),
        .i_ctrl      (sort_ctrl),
        .i_load_data (load_data),
        .o_median    (median)
    );

    assign o_valid            = r_out_valid;
    assign o_period_us        = r_out_period;
    assign o_accepted         = r_out_acc;
    assign o_median_period_us = r_out_median;

endmodule
